### hdl/truecolor_brightness_contrast_gamma_core_defines.svh
// assertion macros shared by the adjustment core
`ifndef TRUECOLOR_BRIGHTNESS_CONTRAST_GAMMA_CORE_DEFINES_SVH
`define TRUECOLOR_BRIGHTNESS_CONTRAST_GAMMA_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TBCG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TBCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tbcg_pkg.sv
// types, constants and helper functions of the adjustment core
package tbcg_pkg;

    localparam int NUM_CHAN  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = 5;

    localparam logic [9:0]  NEUTRAL_PCT  = 10'd100;
    localparam logic [7:0]  BTERM_RST    = 8'd128;
    localparam logic [7:0]  CH_MAX       = 8'hFF;
    localparam logic [7:0]  CH_MIN       = 8'h00;
    localparam logic [8:0]  UPPER_RST    = 9'd255;
    localparam logic [23:0] LOWER_RST    = 24'd0;
    localparam logic [31:0] NARROW_MASK  = 32'h0000_FFFF;
    localparam logic [31:0] RED_RST      = 32'h00FF_0000;
    localparam logic [31:0] GREEN_RST    = 32'h0000_FF00;
    localparam logic [31:0] BLUE_RST     = 32'h0000_00FF;
    // ceil(2^24 / 100), exact for dividends below 199728
    localparam logic [17:0] RECIP_100    = 18'd167773;
    localparam int          RECIP_SHIFT  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS,
        REG_CONTRAST,
        REG_GAMMA_EN,
        REG_RED_MASK,
        REG_GREEN_MASK,
        REG_BLUE_MASK,
        REG_WIDE
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic [8:0]         upper;
        logic signed [23:0] lower;
    } t_bounds;

    typedef struct packed {
        logic [31:0] mask;
        logic [4:0]  off;
        logic        lim_neg;
        logic [4:0]  lim_amt;
    } t_chan_fmt;

    typedef struct packed {
        logic [9:0] contrast;
        logic [7:0] bterm;
        logic       gamma_en;
        logic       wide;
        t_bounds    bounds;
    } t_adj;

    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } t_stage_en;

    typedef struct packed {
        logic       we;
        logic [7:0] index;
        logic [7:0] value;
    } t_table_wr;

    function automatic logic [16:0] div100(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP_100);
        return 17'(p >> RECIP_SHIFT);
    endfunction

    function automatic logic [5:0] bit_index(input logic [32:0] x);
        logic [5:0] idx;
        idx = '0;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) begin
                idx = idx | 6'(i);
            end
        end
        return idx;
    endfunction

    // offset of the lowest set bit, end of its run of ones, and the resulting 8-bit alignment
    function automatic t_chan_fmt fmt_of(input logic [31:0] m);
        logic [31:0]       iso;
        logic [32:0]       y;
        logic [32:0]       yiso;
        logic [5:0]        off6;
        logic [5:0]        rend;
        logic signed [6:0] lim;
        t_chan_fmt         f;
        iso  = m & (~m + 32'd1);
        off6 = bit_index({1'b0, iso});
        y    = {1'b0, m} + {1'b0, iso};
        yiso = y & (~y + 33'd1);
        rend = bit_index(yiso);
        lim  = 7'sd8 + $signed({1'b0, off6}) - $signed({1'b0, rend});
        f.mask    = m;
        f.off     = off6[4:0];
        f.lim_neg = lim[6];
        f.lim_amt = lim[6] ? 5'(-lim) : lim[4:0];
        return f;
    endfunction

endpackage

### hdl/tbcg_ifs.sv
// valid/ready channel interfaces of the adjustment core
interface tbcg_pix_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [31:0] pixel_in;
    logic [7:0] table_index;
    logic [7:0] table_value;

    modport source (output valid, cmd, pixel_in, table_index, table_value, input ready);
    modport sink   (input valid, cmd, pixel_in, table_index, table_value, output ready);
endinterface

interface tbcg_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

interface tbcg_cfg_if;
    import tbcg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tbcg_bounds.sv
// serial divider that derives the clipping bounds from brightness and contrast
`include "truecolor_brightness_contrast_gamma_core_defines.svh"

module tbcg_bounds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [9:0]        i_brightness,
    input  logic [9:0]        i_contrast,
    output logic              o_busy,
    output tbcg_pkg::t_bounds o_bounds
);
    import tbcg_pkg::*;

    t_div_state r_state;
    t_div_state n_state;

    logic             w_load;
    logic             w_step;
    logic             w_finish;

    logic [CNT_W-1:0] r_cnt;
    logic [9:0]       r_div;
    logic [9:0]       r_rem1;
    logic [9:0]       r_rem2;
    logic [16:0]      r_quo1;
    logic [16:0]      r_quo2;
    logic             r_neg1;
    t_bounds          r_bounds;

    logic [16:0]        w_b128;
    logic signed [18:0] w_num1;
    logic [10:0]        w_trial1;
    logic [10:0]        w_trial2;
    logic               w_bit1;
    logic               w_bit2;
    logic signed [18:0] w_up;
    t_bounds            n_bounds;

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        w_load   = 1'b0;
        w_step   = 1'b0;
        w_finish = 1'b0;
        o_busy   = 1'b1;
        case (r_state)
            DIV_IDLE: begin
                w_load = i_start;
                o_busy = 1'b0;
            end
            DIV_RUN:  w_step = 1'b1;
            DIV_DONE: w_finish = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    always_comb begin
        w_b128   = {i_brightness, 7'b0};
        w_num1   = $signed(19'd25600) - $signed({2'b0, w_b128});
        w_trial1 = {r_rem1, r_quo1[16]};
        w_trial2 = {r_rem2, r_quo2[16]};
        w_bit1   = w_trial1 >= {1'b0, r_div};
        w_bit2   = w_trial2 >= {1'b0, r_div};
        w_up     = r_neg1 ? ($signed(19'd128) - $signed({2'b0, r_quo1}))
                          : ($signed(19'd128) + $signed({2'b0, r_quo1}));
        if (r_div == '0) begin
            n_bounds.upper = UPPER_RST;
            n_bounds.lower = LOWER_RST;
        end else begin
            if (w_up > $signed(19'd255)) begin
                n_bounds.upper = UPPER_RST;
            end else if (w_up < $signed(19'd0)) begin
                n_bounds.upper = '0;
            end else begin
                n_bounds.upper = w_up[8:0];
            end
            n_bounds.lower = $signed(24'd128) - $signed({7'b0, r_quo2});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DIV_IDLE;
            r_bounds <= '{upper: UPPER_RST, lower: LOWER_RST};
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_bounds <= n_bounds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cnt  <= '0;
            r_div  <= i_contrast;
            r_rem1 <= '0;
            r_rem2 <= '0;
            r_neg1 <= w_num1 < 0;
            r_quo1 <= (w_num1 < 0) ? 17'(-w_num1) : w_num1[16:0];
            r_quo2 <= w_b128;
        end else if (w_step) begin
            r_cnt  <= r_cnt + CNT_W'(1);
            r_rem1 <= w_bit1 ? 10'(w_trial1 - {1'b0, r_div}) : w_trial1[9:0];
            r_rem2 <= w_bit2 ? 10'(w_trial2 - {1'b0, r_div}) : w_trial2[9:0];
            r_quo1 <= {r_quo1[15:0], w_bit1};
            r_quo2 <= {r_quo2[15:0], w_bit2};
        end
    end

    assign o_bounds = r_bounds;

    `TBCG_ASSERT_SAME(a_start_when_idle, i_start, r_state == DIV_IDLE, "bounds restart while busy")
    `TBCG_ASSERT_NEXT(a_run_ends, r_state == DIV_RUN && r_cnt == CNT_W'(DIV_STEPS - 1), r_state == DIV_DONE, "divider overran its step count")
    `TBCG_ASSERT_NEXT(a_zero_contrast, r_state == DIV_DONE && r_div == '0, o_bounds.upper == UPPER_RST && o_bounds.lower == LOWER_RST, "zero contrast bounds not neutral")

endmodule

### hdl/tbcg_lane.sv
// one colour channel: unpack, scale, clip, gamma lookup and repack
module tbcg_lane (
    input  logic                i_clk,
    input  tbcg_pkg::t_stage_en i_en,
    input  tbcg_pkg::t_adj      i_adj,
    input  tbcg_pkg::t_chan_fmt i_fmt,
    input  logic [31:0]         i_pix,
    input  tbcg_pkg::t_table_wr i_twr,
    output logic [31:0]         o_part
);
    import tbcg_pkg::*;

    logic [7:0] r_gamma [256];

    logic signed [17:0] r_b_prod;
    logic               r_b_hi;
    logic               r_b_lo;
    logic [7:0]         r_c_q;
    logic               r_c_neg;
    logic               r_c_hi;
    logic               r_c_lo;
    logic [7:0]         r_d_r;
    logic [7:0]         r_d_g;

    logic [31:0]        w_sel;
    logic [31:0]        w_nar;
    logic [31:0]        w_wsh;
    logic [7:0]         w_v;
    logic signed [8:0]  w_diff;
    logic signed [17:0] w_prod;
    logic               w_hi;
    logic               w_lo;
    logic [16:0]        w_mag;
    logic [16:0]        w_q;
    logic [7:0]         w_adj;
    logic [7:0]         w_r;
    logic [7:0]         w_ch;
    logic [31:0]        w_rep;

    // stage b: unpack and scale
    always_comb begin
        w_sel  = (i_pix & i_fmt.mask) >> i_fmt.off;
        w_nar  = i_fmt.lim_neg ? (w_sel >> i_fmt.lim_amt) : (w_sel << i_fmt.lim_amt);
        w_wsh  = i_pix >> i_fmt.off;
        w_v    = i_adj.wide ? w_wsh[7:0] : w_nar[7:0];
        w_diff = $signed({1'b0, w_v}) - 9'sd128;
        w_prod = $signed({8'b0, i_adj.contrast}) * 18'(w_diff);
        w_hi   = {1'b0, w_v} > i_adj.bounds.upper;
        w_lo   = $signed({16'b0, w_v}) < i_adj.bounds.lower;
    end

    // stage c: truncating divide by 100
    always_comb begin
        w_mag = r_b_prod[17] ? 17'(-r_b_prod) : r_b_prod[16:0];
        w_q   = div100(w_mag);
    end

    // stage d: offset, clip, table address
    always_comb begin
        w_adj = (r_c_neg ? 8'(-r_c_q) : r_c_q) + i_adj.bterm;
        if (r_c_hi) begin
            w_r = CH_MAX;
        end else if (r_c_lo) begin
            w_r = CH_MIN;
        end else begin
            w_r = w_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_b) begin
            r_b_prod <= w_prod;
            r_b_hi   <= w_hi;
            r_b_lo   <= w_lo;
        end
        if (i_en.ld_c) begin
            r_c_q   <= w_q[7:0];
            r_c_neg <= r_b_prod[17];
            r_c_hi  <= r_b_hi;
            r_c_lo  <= r_b_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_d) begin
            r_d_r <= w_r;
            r_d_g <= r_gamma[w_r];
            if (i_twr.we) begin
                r_gamma[i_twr.index] <= i_twr.value;
            end
        end
    end

    // repack into the pixel format
    always_comb begin
        w_ch   = i_adj.gamma_en ? r_d_g : r_d_r;
        w_rep  = i_fmt.lim_neg ? (32'(w_ch) << i_fmt.lim_amt) : (32'(w_ch) >> i_fmt.lim_amt);
        o_part = (i_adj.wide ? 32'(w_ch) : w_rep) << i_fmt.off;
    end

endmodule

### hdl/truecolor_brightness_contrast_gamma_core.sv
// top level of the truecolor brightness, contrast and gamma core
// pixel channel i_pix: cmd 0 carries a packed pixel, cmd 1 loads one gamma table entry
// result channel o_res: one adjusted pixel per pixel beat, none for table beats
// config channel i_cfg: index selects brightness, contrast, gamma enable, the three
//   channel masks or the pixel width; unknown indexes are ignored
// throughput: one beat per clock while the receiver is ready and no bounds update runs,
//   through five register stages (input, scale, divide by 100, clip and table read, output)
// a brightness or contrast write starts a 17-step serial divider for the clip bounds;
//   both i_pix and i_cfg hold ready low until it finishes
// each colour lane keeps its own copy of the 256-entry gamma table, so table reads
//   of the three channels happen in the same cycle
// reset: neutral settings, bounds 0..255, gamma table contents undefined until loaded
// receiver stall: the output register holds its beat, stages behind it fill their
//   empty slots and then stop; nothing is dropped or repeated
`include "truecolor_brightness_contrast_gamma_core_defines.svh"

module truecolor_brightness_contrast_gamma_core #(
    parameter int PIXEL_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbcg_pix_if.sink    i_pix,
    tbcg_cfg_if.sink    i_cfg,
    tbcg_res_if.source  o_res
);
    import tbcg_pkg::*;

    localparam logic [31:0] WIDE_MASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);

    logic [9:0] r_brightness;
    logic [9:0] r_contrast;
    logic       r_gamma_en;
    logic       r_wide;
    logic [7:0] r_bterm;
    logic       r_start;
    t_chan_fmt  r_fmt [NUM_CHAN];

    logic        r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic        r_a_cmd, r_b_cmd, r_c_cmd, r_d_cmd;
    logic [31:0] r_a_pix, r_b_pix, r_c_pix, r_d_pix, r_e_pix;
    logic [7:0]  r_a_idx, r_b_idx, r_c_idx;
    logic [7:0]  r_a_val, r_b_val, r_c_val;

    logic        w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_e;
    logic        w_busy;
    logic        w_cfg_beat;
    logic        w_neutral;
    logic [31:0] w_size_mask;
    logic [16:0] w_bprod;
    logic [16:0] w_bq;
    logic [31:0] w_part [NUM_CHAN];
    logic [31:0] n_e_pix;
    t_bounds     w_bounds;
    t_adj        w_adj;
    t_stage_en   w_en;
    t_table_wr   w_twr;

    tbcg_bounds u_bounds (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_brightness (r_brightness),
        .i_contrast   (r_contrast),
        .o_busy       (w_busy),
        .o_bounds     (w_bounds)
    );

    // configuration
    assign i_cfg.ready = !w_busy && !r_start;
    assign w_cfg_beat  = i_cfg.valid && i_cfg.ready;
    assign w_bprod     = {i_cfg.data[9:0], 7'b0};
    assign w_bq        = div100(w_bprod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= NEUTRAL_PCT;
            r_contrast   <= NEUTRAL_PCT;
            r_gamma_en   <= 1'b0;
            r_wide       <= 1'b1;
            r_bterm      <= BTERM_RST;
            r_start      <= 1'b0;
            r_fmt[0]     <= fmt_of(RED_RST);
            r_fmt[1]     <= fmt_of(GREEN_RST);
            r_fmt[2]     <= fmt_of(BLUE_RST);
        end else begin
            r_start <= 1'b0;
            if (w_cfg_beat) begin
                case (i_cfg.index)
                    REG_BRIGHTNESS: begin
                        r_brightness <= i_cfg.data[9:0];
                        r_bterm      <= w_bq[7:0];
                        r_start      <= 1'b1;
                    end
                    REG_CONTRAST: begin
                        r_contrast <= i_cfg.data[9:0];
                        r_start    <= 1'b1;
                    end
                    REG_GAMMA_EN:   r_gamma_en <= i_cfg.data[0];
                    REG_RED_MASK:   r_fmt[0]   <= fmt_of(i_cfg.data);
                    REG_GREEN_MASK: r_fmt[1]   <= fmt_of(i_cfg.data);
                    REG_BLUE_MASK:  r_fmt[2]   <= fmt_of(i_cfg.data);
                    REG_WIDE:       r_wide     <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    // pipeline flow control
    always_comb begin
        w_rdy_e = !r_e_v || o_res.ready;
        w_rdy_d = !r_d_v || w_rdy_e;
        w_rdy_c = !r_c_v || w_rdy_d;
        w_rdy_b = !r_b_v || w_rdy_c;
        w_rdy_a = !r_a_v || w_rdy_b;
    end

    assign i_pix.ready = w_rdy_a && !w_busy && !r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_v <= i_pix.valid && i_pix.ready;
            if (w_rdy_b) r_b_v <= r_a_v;
            if (w_rdy_c) r_c_v <= r_b_v;
            if (w_rdy_d) r_d_v <= r_c_v;
            if (w_rdy_e) r_e_v <= r_d_v && !r_d_cmd;
        end
    end

    assign w_size_mask = r_wide ? WIDE_MASK : NARROW_MASK;
    assign w_neutral   = (r_brightness == NEUTRAL_PCT) && (r_contrast == NEUTRAL_PCT)
                         && !r_gamma_en;

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_cmd <= i_pix.cmd;
            r_a_pix <= i_pix.pixel_in & w_size_mask;
            r_a_idx <= i_pix.table_index;
            r_a_val <= i_pix.table_value;
        end
        if (w_rdy_b) begin
            r_b_cmd <= r_a_cmd;
            r_b_pix <= r_a_pix;
            r_b_idx <= r_a_idx;
            r_b_val <= r_a_val;
        end
        if (w_rdy_c) begin
            r_c_cmd <= r_b_cmd;
            r_c_pix <= r_b_pix;
            r_c_idx <= r_b_idx;
            r_c_val <= r_b_val;
        end
        if (w_rdy_d) begin
            r_d_cmd <= r_c_cmd;
            r_d_pix <= r_c_pix;
        end
        if (w_rdy_e) begin
            r_e_pix <= n_e_pix;
        end
    end

    // lanes
    always_comb begin
        w_adj.contrast = r_contrast;
        w_adj.bterm    = r_bterm;
        w_adj.gamma_en = r_gamma_en;
        w_adj.wide     = r_wide;
        w_adj.bounds   = w_bounds;
        w_en.ld_b      = w_rdy_b;
        w_en.ld_c      = w_rdy_c;
        w_en.ld_d      = w_rdy_d;
        w_twr.we       = w_rdy_d && r_c_v && r_c_cmd;
        w_twr.index    = r_c_idx;
        w_twr.value    = r_c_val;
    end

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        tbcg_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_adj  (w_adj),
            .i_fmt  (r_fmt[g]),
            .i_pix  (r_a_pix),
            .i_twr  (w_twr),
            .o_part (w_part[g])
        );
    end

    assign n_e_pix = (w_neutral ? r_d_pix : (w_part[0] | w_part[1] | w_part[2]))
                     & w_size_mask;

    assign o_res.valid     = r_e_v;
    assign o_res.pixel_out = r_e_pix;

    `TBCG_ASSERT_SAME(a_no_beat_while_busy, i_pix.valid && i_pix.ready, !w_busy && !r_start, "pixel beat taken while bounds update")
    `TBCG_ASSERT_NEXT(a_stage_c_holds, r_c_v && !w_rdy_d, r_c_v, "stalled stage lost its beat")
    `TBCG_ASSERT_NEXT(a_table_beat_silent, w_rdy_e && r_d_v && r_d_cmd, !r_e_v, "table beat reached the output")

endmodule

### dv/tb_truecolor_brightness_contrast_gamma_core.sv
// self-checking testbench of the truecolor brightness, contrast and gamma core
`timescale 1ns / 100ps

module tb_truecolor_brightness_contrast_gamma_core;
    import tbcg_pkg::*;

    localparam logic                 CMD_PIXEL       = 1'b0;
    localparam logic                 CMD_TABLE       = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_NONE        = 3'd7;
    localparam int                   SETTLE_CYCLES   = 12;
    localparam int                   NUM_PHASES      = 16;
    localparam int                   BEATS_PER_PHASE = 56;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [31:0]          cfg_data;
        logic                 cmd;
        logic [31:0]          pixel;
        logic [7:0]           lut_idx;
        logic [7:0]           lut_val;
        bit                   typed;
        logic [31:0]          want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    tbcg_pix_if pix_if ();
    tbcg_cfg_if cfg_if ();
    tbcg_res_if res_if ();

    truecolor_brightness_contrast_gamma_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // shadow of the core's settings and state
    logic [9:0]  bright_pct;
    logic [9:0]  contrast_pct;
    logic        gamma_on;
    logic [31:0] lane_mask [3];
    logic        wide_mode;
    logic [7:0]  gamma_lut [256];
    int          upper_lim;
    int          lower_lim;

    logic [31:0] pending_pixels [$];
    logic [31:0] oldest_pixel;
    t_stim_row   directed_rows [$];

    int send_idle_pct;
    int stall_pct;
    int fail_count;
    int pixels_sent;
    int pixels_checked;
    int lut_loads;
    int reg_writes;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void refresh_bounds();
        int b;
        int c;
        int u;
        if (contrast_pct != 10'd0) begin
            b = int'(bright_pct);
            c = int'(contrast_pct);
            u = (25600 - 128 * b) / c + 128;
            if (u > 255) u = 255;
            if (u < 0) u = 0;
            upper_lim = u;
            lower_lim = (-128 * b) / c + 128;
        end else begin
            upper_lim = 255;
            lower_lim = 0;
        end
    endfunction

    function automatic int lowest_one(input logic [31:0] m);
        int n;
        n = 0;
        if (m == '0) return 0;
        while (!m[n]) n++;
        return n;
    endfunction

    function automatic int run_stop(input logic [31:0] m);
        int n;
        if (m == '0) return 0;
        n = lowest_one(m) + 1;
        while (n < 32 && m[n]) n++;
        return n;
    endfunction

    function automatic logic [7:0] adjust_channel(input logic [7:0] v);
        int         vi;
        int         t;
        logic [7:0] r;
        vi = int'(v);
        if (vi > upper_lim) begin
            r = 8'hFF;
        end else if (vi < lower_lim) begin
            r = 8'h00;
        end else begin
            t = int'(contrast_pct) * (vi - 128) / 100 + 128 * int'(bright_pct) / 100;
            r = t[7:0];
        end
        if (gamma_on) r = gamma_lut[r];
        return r;
    endfunction

    function automatic logic [31:0] wide_lane(input logic [31:0] px, input logic [31:0] m);
        int          off;
        logic [31:0] v;
        off = lowest_one(m);
        v = px >> off;
        v = {24'd0, adjust_channel(v[7:0])};
        return v << off;
    endfunction

    function automatic logic [31:0] narrow_lane(input logic [31:0] px, input logic [31:0] m);
        int          off;
        int          lim;
        logic [31:0] v;
        off = lowest_one(m);
        lim = 8 + off - run_stop(m);
        v = (px & m) >> off;
        if (lim >= 0) v = v << lim;
        else v = v >> (-lim);
        v = {24'd0, adjust_channel(v[7:0])};
        if (lim >= 0) v = v >> lim;
        else v = v << (-lim);
        return v << off;
    endfunction

    function automatic logic [31:0] adjust_pixel(input logic [31:0] px_in);
        logic [31:0] size_mask;
        logic [31:0] px;
        logic [31:0] res;
        size_mask = wide_mode ? 32'hFFFF_FFFF : NARROW_MASK;
        px = px_in & size_mask;
        if (bright_pct == NEUTRAL_PCT && contrast_pct == NEUTRAL_PCT && !gamma_on) return px;
        if (wide_mode) begin
            res = wide_lane(px, lane_mask[0]) | wide_lane(px, lane_mask[1])
                | wide_lane(px, lane_mask[2]);
        end else begin
            res = narrow_lane(px, lane_mask[0]) | narrow_lane(px, lane_mask[1])
                | narrow_lane(px, lane_mask[2]);
        end
        return res & size_mask;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [31:0] data);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_stim_row pix_row(input logic [31:0] px, input bit typed,
                                          input logic [31:0] want);
        t_stim_row r;
        r = '{default: '0};
        r.cmd = CMD_PIXEL;
        r.pixel = px;
        r.lut_idx = 8'($urandom());
        r.lut_val = 8'($urandom());
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_stim_row lut_row(input logic [7:0] idx, input logic [7:0] val);
        t_stim_row r;
        r = '{default: '0};
        r.cmd = CMD_TABLE;
        r.pixel = $urandom();
        r.lut_idx = idx;
        r.lut_val = val;
        return r;
    endfunction

    function automatic logic [9:0] pick_pct();
        case ($urandom_range(11))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd1000;
            3: return NEUTRAL_PCT;
            4: return 10'($urandom_range(1, 1023));
            default: return 10'($urandom_range(40, 220));
        endcase
    endfunction

    function automatic logic [31:0] pick_mask(input int lane, input bit narrow);
        logic [63:0] run;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3, 4, 5, 6: begin
                run = (64'd1 << $urandom_range(1, 12)) - 64'd1;
                return 32'(run << $urandom_range(0, narrow ? 15 : 28));
            end
            default: begin
                case (lane)
                    0: return narrow ? 32'h0000_F800 : RED_RST;
                    1: return narrow ? 32'h0000_07E0 : GREEN_RST;
                    default: return narrow ? 32'h0000_001F : BLUE_RST;
                endcase
            end
        endcase
    endfunction

    // unused upper data bits carry noise now and then
    function automatic logic [31:0] pad_bits(input logic [31:0] value, input logic [31:0] used);
        if ($urandom_range(3) == 0) return ($urandom() & ~used) | value;
        return value;
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        px = $urandom();
        if ($urandom_range(3) == 0) begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(3))
                    0: px[8*k +: 8] = 8'h00;
                    1: px[8*k +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return px;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        reg_writes++;
        case (idx)
            REG_BRIGHTNESS: begin
                bright_pct = data[9:0];
                refresh_bounds();
            end
            REG_CONTRAST: begin
                contrast_pct = data[9:0];
                refresh_bounds();
            end
            REG_GAMMA_EN:   gamma_on = data[0];
            REG_RED_MASK:   lane_mask[0] = data;
            REG_GREEN_MASK: lane_mask[1] = data;
            REG_BLUE_MASK:  lane_mask[2] = data;
            REG_WIDE:       wide_mode = data[0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic cmd, input logic [31:0] px, input logic [7:0] idx,
                             input logic [7:0] val, input bit typed, input logic [31:0] want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.cmd         <= cmd;
        pix_if.pixel_in    <= px;
        pix_if.table_index <= idx;
        pix_if.table_value <= val;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        if (cmd == CMD_TABLE) begin
            gamma_lut[idx] = val;
            lut_loads++;
        end else begin
            pending_pixels.push_back(typed ? want : adjust_pixel(px));
            pixels_sent++;
        end
    endtask

    // hold the sender off until the core has drained, table loads included
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_settings();
        if ($urandom_range(1)) write_reg(REG_BRIGHTNESS, pad_bits({22'd0, pick_pct()}, 32'h3FF));
        if ($urandom_range(1)) write_reg(REG_CONTRAST, pad_bits({22'd0, pick_pct()}, 32'h3FF));
        if ($urandom_range(1)) write_reg(REG_GAMMA_EN, pad_bits(32'($urandom_range(1)), 32'h1));
        if ($urandom_range(1)) write_reg(REG_WIDE, pad_bits(32'($urandom_range(1)), 32'h1));
        if ($urandom_range(1)) write_reg(REG_RED_MASK, pick_mask(0, !wide_mode));
        if ($urandom_range(1)) write_reg(REG_GREEN_MASK, pick_mask(1, !wide_mode));
        if ($urandom_range(1)) write_reg(REG_BLUE_MASK, pick_mask(2, !wide_mode));
        if ($urandom_range(7) == 0) write_reg(REG_NONE, $urandom());
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: beat with nothing expected, actual %08h", res_if.pixel_out);
                fail_count++;
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                pixels_checked++;
                if (res_if.pixel_out !== oldest_pixel) begin
                    $error("pixel_out: expected %08h, actual %08h",
                           oldest_pixel, res_if.pixel_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb_truecolor_brightness_contrast_gamma_core failed");
        $finish;
    end

    initial begin
        t_stim_row row;
        bit        prev_cfg;

        i_rst_n            <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.cmd         <= CMD_PIXEL;
        pix_if.pixel_in    <= '0;
        pix_if.table_index <= '0;
        pix_if.table_value <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;

        bright_pct   = NEUTRAL_PCT;
        contrast_pct = NEUTRAL_PCT;
        gamma_on     = 1'b0;
        lane_mask[0] = RED_RST;
        lane_mask[1] = GREEN_RST;
        lane_mask[2] = BLUE_RST;
        wide_mode    = 1'b1;
        upper_lim    = 255;
        lower_lim    = 0;
        foreach (gamma_lut[i]) gamma_lut[i] = 8'h00;
        send_idle_pct  = 0;
        stall_pct      = 0;
        fail_count     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        lut_loads      = 0;
        reg_writes     = 0;

        // neutral after reset, both pixel sizes
        directed_rows.push_back(pix_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
        directed_rows.push_back(pix_row(32'h0000_0000, 1, 32'h0000_0000));
        directed_rows.push_back(pix_row(32'h1234_5678, 1, 32'h1234_5678));
        directed_rows.push_back(reg_row(REG_WIDE, 32'd0));
        directed_rows.push_back(pix_row(32'hDEAD_BEEF, 1, 32'h0000_BEEF));
        directed_rows.push_back(reg_row(REG_WIDE, 32'd1));
        directed_rows.push_back(lut_row(8'h00, 8'hA5));
        directed_rows.push_back(lut_row(8'hFF, 8'h3C));
        // zero contrast opens the bounds, zero brightness flattens every channel
        directed_rows.push_back(reg_row(REG_BRIGHTNESS, 32'd0));
        directed_rows.push_back(reg_row(REG_CONTRAST, 32'd0));
        directed_rows.push_back(pix_row(32'hFFFF_FFFF, 1, 32'h0000_0000));
        directed_rows.push_back(reg_row(REG_GAMMA_EN, 32'd1));
        directed_rows.push_back(pix_row(32'h5A5A_5A5A, 1, 32'h00A5_A5A5));
        directed_rows.push_back(reg_row(REG_GAMMA_EN, 32'd0));
        directed_rows.push_back(reg_row(REG_BRIGHTNESS, 32'd1023));
        directed_rows.push_back(pix_row(32'h00FF_0080, 1, 32'h001D_1D1D));
        directed_rows.push_back(reg_row(REG_CONTRAST, 32'd1023));
        directed_rows.push_back(pix_row(32'h001A_1B80, 0, '0));
        directed_rows.push_back(pix_row(32'h00FF_7F00, 0, '0));
        // gamma alone, only the two loaded entries are hit
        directed_rows.push_back(reg_row(REG_BRIGHTNESS, 32'd100));
        directed_rows.push_back(reg_row(REG_CONTRAST, 32'd100));
        directed_rows.push_back(reg_row(REG_GAMMA_EN, 32'd1));
        directed_rows.push_back(pix_row(32'h00FF_00FF, 1, 32'h003C_A53C));
        directed_rows.push_back(reg_row(REG_GAMMA_EN, 32'd0));
        directed_rows.push_back(reg_row(REG_BRIGHTNESS, 32'd150));
        directed_rows.push_back(reg_row(REG_CONTRAST, 32'd80));
        directed_rows.push_back(pix_row(32'h80FF_4010, 0, '0));
        directed_rows.push_back(reg_row(REG_RED_MASK, 32'h0000_0000));
        directed_rows.push_back(reg_row(REG_GREEN_MASK, 32'hFFFF_FFFF));
        directed_rows.push_back(reg_row(REG_BLUE_MASK, 32'h0000_00F0));
        directed_rows.push_back(pix_row(32'hC3A5_5A3C, 0, '0));
        // 565 layout, then a run longer than eight bits
        directed_rows.push_back(reg_row(REG_WIDE, 32'd0));
        directed_rows.push_back(reg_row(REG_RED_MASK, 32'h0000_F800));
        directed_rows.push_back(reg_row(REG_GREEN_MASK, 32'h0000_07E0));
        directed_rows.push_back(reg_row(REG_BLUE_MASK, 32'h0000_001F));
        directed_rows.push_back(pix_row(32'hFFFF_1234, 0, '0));
        directed_rows.push_back(pix_row(32'h0000_FFFF, 0, '0));
        directed_rows.push_back(reg_row(REG_RED_MASK, 32'h0001_FF80));
        directed_rows.push_back(reg_row(REG_GREEN_MASK, 32'h0000_0FF0));
        directed_rows.push_back(reg_row(REG_BLUE_MASK, 32'h0000_0000));
        directed_rows.push_back(pix_row(32'h0000_F0F0, 0, '0));
        directed_rows.push_back(pix_row(32'h1234_5678, 0, '0));
        directed_rows.push_back(reg_row(REG_NONE, 32'hFFFF_FFFF));
        directed_rows.push_back(pix_row(32'hABCD_EF01, 0, '0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!prev_cfg) settle();
                write_reg(row.cfg_idx, row.cfg_data);
            end else begin
                cfg_if.valid <= 1'b0;
                send_beat(row.cmd, row.pixel, row.lut_idx, row.lut_val, row.typed, row.want);
            end
            prev_cfg = row.is_cfg;
        end

        // fill the whole gamma table so that gamma may be on from here
        settle();
        send_idle_pct = 16;
        stall_pct     = 16;
        for (int i = 0; i < 256; i++) begin
            send_beat(CMD_TABLE, $urandom(), 8'(i), 8'($urandom()), 0, '0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default: begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase
            random_settings();
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 12) begin
                    send_beat(CMD_TABLE, $urandom(), 8'($urandom()), 8'($urandom()), 0, '0);
                end else begin
                    send_beat(CMD_PIXEL, random_pixel(), 8'($urandom()), 8'($urandom()), 0, '0);
                end
            end
        end

        settle();
        $display("checked %0d of %0d pixels over %0d register writes and %0d phases",
                 pixels_checked, pixels_sent, reg_writes, NUM_PHASES);
        $display("gamma table loads: %0d, both pixel sizes and all idle patterns used",
                 lut_loads);
        if (fail_count == 0) begin
            $display("tb_truecolor_brightness_contrast_gamma_core passed");
        end else begin
            $display("tb_truecolor_brightness_contrast_gamma_core failed");
        end
        $finish;
    end

endmodule
